### hdl/bfts_pkg.sv
// Package for the best-F1 threshold sweep block.
// Holds widths, payload structs, operation codes and the controller/datapath link types.
// No dependencies.
`default_nettype none

package bfts_pkg;

  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int CNT_W      = COUNT_BITS + 1;
  localparam int Q_W        = FRAC_BITS + 1;
  localparam int EDGE_W     = 32;
  localparam int NOM_W      = 48;
  localparam int CFG_W      = 48;
  localparam int CFG_IDX_W  = 2;

  localparam int KE_W  = EDGE_W + COUNT_BITS;
  localparam int KN_W  = NOM_W + COUNT_BITS;
  localparam int REL_W = KE_W + COUNT_BITS;
  localparam int TP_W  = KE_W + CNT_W;
  localparam int FP_W  = KN_W + CNT_W;
  localparam int RET_W = FP_W + 1;
  localparam int DIV_W = RET_W + 1;
  localparam int MUL_W = FP_W;

  localparam int STEP_W   = $clog2(CNT_W);
  localparam int MUL_LAST = CNT_W - 1;
  localparam int DIV_LAST = FRAC_BITS - 1;

  localparam logic [Q_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_EDGES       = 2'd0,
    REG_TOTAL_NON_EDGES   = 2'd1,
    REG_SAMPLED_EDGES     = 2'd2,
    REG_SAMPLED_NON_EDGES = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MOP_KE  = 3'd0,
    MOP_KN  = 3'd1,
    MOP_REL = 3'd2,
    MOP_TPN = 3'd3,
    MOP_FPN = 3'd4
  } mul_op_t;

  typedef enum logic [1:0] {
    DOP_PREC = 2'd0,
    DOP_REC  = 2'd1,
    DOP_F1   = 2'd2
  } div_op_t;

  typedef struct packed {
    logic is_edge;
    logic last;
  } sample_t;

  typedef struct packed {
    logic [Q_W-1:0]   best_precision;
    logic [Q_W-1:0]   best_recall;
    logic [Q_W-1:0]   best_f1;
    logic [CNT_W-1:0] best_position;
    logic             count_error;
  } result_t;

  typedef struct packed {
    logic    capture;
    logic    mul_load;
    logic    mul_step;
    logic    mul_store;
    mul_op_t mul_op;
    logic    sum;
    logic    div_load;
    logic    div_step;
    logic    div_store;
    div_op_t div_op;
    logic    update;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### hdl/best_f1_threshold_sweep_top.sv
// Top level of the best-F1 threshold sweep block.
// Instantiates bfts_ctrl and bfts_dp; depends on bfts_pkg.
`default_nettype none

// Each accepted sample updates the edge and non-edge counts, then precision, recall and F1
// are formed by one shared restoring divider that produces one quotient bit per cycle.
// A sample occupies the block through accept, one sum, three divisions (each a load and
// its quotient steps) and one best update; a sample marked last then adds an emit step to
// move the result into the output register, and waits there only while an earlier result
// is still stalled. The first sample after reset or after any configuration write first
// has a shift-add multiplier, one multiplier bit per cycle, recompute the five scale
// products in five passes. Configuration writes are always accepted.
// Results are held in an output register, so the next sample is taken while a result
// waits.
module best_f1_threshold_sweep_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_valid,
  output logic                                sample_stall,
  input  wire bfts_pkg::sample_t              sample,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output bfts_pkg::result_t                   result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bfts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bfts_pkg::CFG_W-1:0]     cfg_data
);

  bfts_pkg::cmd_t    cmd;
  bfts_pkg::status_t status;
  logic              cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  bfts_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .cfg_write    (cfg_write),
    .status       (status),
    .cmd          (cmd)
  );

  bfts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

### hdl/bfts_dp.sv
// Datapath of the best-F1 threshold sweep: configuration registers, sweep counters,
// shift-add multiplier, restoring fraction divider, best tracking and result register.
// Depends on bfts_pkg.
`default_nettype none

module bfts_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire bfts_pkg::sample_t              sample,
  input  wire logic                           cfg_write,
  input  wire logic [bfts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bfts_pkg::CFG_W-1:0]     cfg_data,
  input  wire bfts_pkg::cmd_t                 cmd,
  output bfts_pkg::status_t                   status,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output bfts_pkg::result_t                   result
);

  logic [bfts_pkg::EDGE_W-1:0]     total_edges;
  logic [bfts_pkg::NOM_W-1:0]      total_non_edges;
  logic [bfts_pkg::COUNT_BITS-1:0] sampled_edges;
  logic [bfts_pkg::COUNT_BITS-1:0] sampled_non_edges;

  logic [bfts_pkg::CNT_W-1:0] edges_seen;
  logic [bfts_pkg::CNT_W-1:0] non_edges_seen;
  logic [bfts_pkg::CNT_W-1:0] position;
  logic [bfts_pkg::TP_W-1:0]  tpn;
  logic [bfts_pkg::FP_W-1:0]  fpn;
  logic [bfts_pkg::Q_W-1:0]   top_f1;
  logic [bfts_pkg::Q_W-1:0]   top_precision;
  logic [bfts_pkg::Q_W-1:0]   top_recall;
  logic [bfts_pkg::CNT_W-1:0] top_position;
  logic                       have_top;
  logic                       last_r;

  logic [bfts_pkg::KE_W-1:0]  ke;
  logic [bfts_pkg::KN_W-1:0]  kn;
  logic [bfts_pkg::REL_W-1:0] rel;
  logic [bfts_pkg::RET_W-1:0] ret;
  logic [bfts_pkg::RET_W-1:0] fden;

  logic [bfts_pkg::MUL_W-1:0] acc;
  logic [bfts_pkg::MUL_W-1:0] mc;
  logic [bfts_pkg::CNT_W-1:0] mp;

  logic [bfts_pkg::DIV_W-1:0]     rem;
  logic [bfts_pkg::RET_W-1:0]     den;
  logic [bfts_pkg::FRAC_BITS-1:0] q;
  logic                           div_ok;
  logic                           div_sat;

  logic [bfts_pkg::Q_W-1:0] cand_precision;
  logic [bfts_pkg::Q_W-1:0] cand_recall;
  logic [bfts_pkg::Q_W-1:0] cand_f1;

  logic                           err;
  logic [bfts_pkg::CNT_W-1:0]     e_inc;
  logic [bfts_pkg::CNT_W-1:0]     n_inc;
  logic [bfts_pkg::MUL_W-1:0]     mul_sum;
  logic [bfts_pkg::MUL_W-1:0]     ld_mc;
  logic [bfts_pkg::CNT_W-1:0]     ld_mp;
  logic [bfts_pkg::DIV_W-1:0]     ld_num;
  logic [bfts_pkg::RET_W-1:0]     ld_den;
  logic                           ld_ok;
  logic [bfts_pkg::DIV_W-1:0]     rem_sh;
  logic [bfts_pkg::DIV_W-1:0]     den_ext;
  logic                           rem_ge;
  logic [bfts_pkg::FRAC_BITS-1:0] q_next;
  logic [bfts_pkg::Q_W-1:0]       q_final;

  assign err     = (sampled_edges == '0) || (sampled_non_edges == '0);
  assign e_inc   = edges_seen + 1'b1;
  assign n_inc   = non_edges_seen + 1'b1;
  assign mul_sum = mp[0] ? (acc + mc) : acc;

  assign rem_sh  = {rem[bfts_pkg::DIV_W-2:0], 1'b0};
  assign den_ext = {1'b0, den};
  assign rem_ge  = (rem_sh >= den_ext);
  assign q_next  = {q[bfts_pkg::FRAC_BITS-2:0], rem_ge};
  assign q_final = !div_ok ? '0 : (div_sat ? bfts_pkg::ONE_Q : {1'b0, q_next});

  assign status.last     = last_r;
  assign status.out_free = !result_valid || !result_stall;

  always_comb begin
    case (cmd.mul_op)
      bfts_pkg::MOP_KE: begin
        ld_mc = bfts_pkg::MUL_W'(total_edges);
        ld_mp = bfts_pkg::CNT_W'(sampled_non_edges);
      end
      bfts_pkg::MOP_KN: begin
        ld_mc = bfts_pkg::MUL_W'(total_non_edges);
        ld_mp = bfts_pkg::CNT_W'(sampled_edges);
      end
      bfts_pkg::MOP_REL: begin
        ld_mc = bfts_pkg::MUL_W'(ke);
        ld_mp = bfts_pkg::CNT_W'(sampled_edges);
      end
      bfts_pkg::MOP_TPN: begin
        ld_mc = bfts_pkg::MUL_W'(ke);
        ld_mp = edges_seen;
      end
      bfts_pkg::MOP_FPN: begin
        ld_mc = bfts_pkg::MUL_W'(kn);
        ld_mp = non_edges_seen;
      end
      default: begin
        ld_mc = '0;
        ld_mp = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.div_op)
      bfts_pkg::DOP_PREC: begin
        ld_num = bfts_pkg::DIV_W'(tpn);
        ld_den = ret;
        ld_ok  = !err && (ret != '0);
      end
      bfts_pkg::DOP_REC: begin
        ld_num = bfts_pkg::DIV_W'(edges_seen);
        ld_den = bfts_pkg::RET_W'(sampled_edges);
        ld_ok  = !err && (total_edges != '0);
      end
      bfts_pkg::DOP_F1: begin
        ld_num = bfts_pkg::DIV_W'({tpn, 1'b0});
        ld_den = fden;
        ld_ok  = !err && (fden != '0);
      end
      default: begin
        ld_num = '0;
        ld_den = '0;
        ld_ok  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_edges       <= '0;
      total_non_edges   <= '0;
      sampled_edges     <= bfts_pkg::COUNT_BITS'(1);
      sampled_non_edges <= bfts_pkg::COUNT_BITS'(1);
      edges_seen        <= '0;
      non_edges_seen    <= '0;
      position          <= '0;
      tpn               <= '0;
      fpn               <= '0;
      top_f1            <= '0;
      top_precision     <= '0;
      top_recall        <= '0;
      top_position      <= '0;
      have_top          <= 1'b0;
      result_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          bfts_pkg::REG_TOTAL_EDGES:       total_edges <= cfg_data[bfts_pkg::EDGE_W-1:0];
          bfts_pkg::REG_TOTAL_NON_EDGES:   total_non_edges <= cfg_data[bfts_pkg::NOM_W-1:0];
          bfts_pkg::REG_SAMPLED_EDGES:     sampled_edges <= cfg_data[bfts_pkg::COUNT_BITS-1:0];
          bfts_pkg::REG_SAMPLED_NON_EDGES: begin
            sampled_non_edges <= cfg_data[bfts_pkg::COUNT_BITS-1:0];
          end
          default: ;
        endcase
      end
      if (cmd.capture) begin
        if (sample.is_edge) begin
          edges_seen <= e_inc;
          tpn        <= (e_inc == '0) ? '0 : tpn + bfts_pkg::TP_W'(ke);
        end else begin
          non_edges_seen <= n_inc;
          fpn            <= (n_inc == '0) ? '0 : fpn + bfts_pkg::FP_W'(kn);
        end
      end
      if (cmd.mul_store) begin
        case (cmd.mul_op)
          bfts_pkg::MOP_TPN: tpn <= mul_sum[bfts_pkg::TP_W-1:0];
          bfts_pkg::MOP_FPN: fpn <= mul_sum[bfts_pkg::FP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        if (!have_top || (cand_f1 > top_f1)) begin
          have_top      <= 1'b1;
          top_f1        <= cand_f1;
          top_precision <= cand_precision;
          top_recall    <= cand_recall;
          top_position  <= position;
        end
        position <= position + 1'b1;
      end
      if (cmd.emit) begin
        result_valid   <= 1'b1;
        edges_seen     <= '0;
        non_edges_seen <= '0;
        position       <= '0;
        tpn            <= '0;
        fpn            <= '0;
        top_f1         <= '0;
        top_precision  <= '0;
        top_recall     <= '0;
        top_position   <= '0;
        have_top       <= 1'b0;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      last_r <= sample.last;
    end
    if (cmd.mul_load) begin
      acc <= '0;
      mc  <= ld_mc;
      mp  <= ld_mp;
    end
    if (cmd.mul_step) begin
      acc <= mul_sum;
      mc  <= {mc[bfts_pkg::MUL_W-2:0], 1'b0};
      mp  <= {1'b0, mp[bfts_pkg::CNT_W-1:1]};
    end
    if (cmd.mul_store) begin
      case (cmd.mul_op)
        bfts_pkg::MOP_KE:  ke <= mul_sum[bfts_pkg::KE_W-1:0];
        bfts_pkg::MOP_KN:  kn <= mul_sum[bfts_pkg::KN_W-1:0];
        bfts_pkg::MOP_REL: rel <= mul_sum[bfts_pkg::REL_W-1:0];
        default: ;
      endcase
    end
    if (cmd.sum) begin
      ret <= bfts_pkg::RET_W'(tpn) + bfts_pkg::RET_W'(fpn);
    end
    if (cmd.div_load) begin
      rem     <= ld_num;
      den     <= ld_den;
      q       <= '0;
      div_ok  <= ld_ok;
      div_sat <= (ld_num >= {1'b0, ld_den});
      if (cmd.div_op == bfts_pkg::DOP_PREC) begin
        fden <= ret + bfts_pkg::RET_W'(rel);
      end
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? (rem_sh - den_ext) : rem_sh;
      q   <= q_next;
    end
    if (cmd.div_store) begin
      case (cmd.div_op)
        bfts_pkg::DOP_PREC: cand_precision <= q_final;
        bfts_pkg::DOP_REC:  cand_recall <= q_final;
        bfts_pkg::DOP_F1:   cand_f1 <= q_final;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      result.count_error <= err;
      if (err) begin
        result.best_precision <= '0;
        result.best_recall    <= '0;
        result.best_f1        <= '0;
        result.best_position  <= '0;
      end else begin
        result.best_precision <= top_precision;
        result.best_recall    <= top_recall;
        result.best_f1        <= top_f1;
        result.best_position  <= top_position;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/bfts_ctrl.sv
// Controller of the best-F1 threshold sweep: sequences scale-factor recomputation,
// the three fraction divisions, best update and result hand-off.
// Depends on bfts_pkg.
`default_nettype none

module bfts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_stall,
  input  wire logic              cfg_write,
  input  wire bfts_pkg::status_t status,
  output bfts_pkg::cmd_t         cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MLOAD  = 8'b0000_0010,
    S_MSTEP  = 8'b0000_0100,
    S_SUM    = 8'b0000_1000,
    S_DLOAD  = 8'b0001_0000,
    S_DSTEP  = 8'b0010_0000,
    S_UPDATE = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [bfts_pkg::STEP_W-1:0] step;
  logic [bfts_pkg::STEP_W-1:0] step_next;
  bfts_pkg::mul_op_t           mop;
  bfts_pkg::mul_op_t           mop_next;
  bfts_pkg::div_op_t           dop;
  bfts_pkg::div_op_t           dop_next;
  logic                        dirty;
  logic                        dirty_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      mop   <= bfts_pkg::MOP_KE;
      dop   <= bfts_pkg::DOP_PREC;
      dirty <= 1'b1;
    end else begin
      state <= state_next;
      step  <= step_next;
      mop   <= mop_next;
      dop   <= dop_next;
      dirty <= dirty_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    mop_next     = mop;
    dop_next     = dop;
    dirty_next   = dirty;
    sample_stall = 1'b1;
    cmd          = '0;
    cmd.mul_op   = mop;
    cmd.div_op   = dop;
    case (state)
      S_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.capture = 1'b1;
          if (dirty) begin
            mop_next   = bfts_pkg::MOP_KE;
            state_next = S_MLOAD;
          end else begin
            state_next = S_SUM;
          end
        end
      end
      S_MLOAD: begin
        cmd.mul_load = 1'b1;
        step_next    = '0;
        state_next   = S_MSTEP;
      end
      S_MSTEP: begin
        cmd.mul_step = 1'b1;
        if (step == bfts_pkg::STEP_W'(bfts_pkg::MUL_LAST)) begin
          cmd.mul_store = 1'b1;
          state_next    = S_MLOAD;
          case (mop)
            bfts_pkg::MOP_KE:  mop_next = bfts_pkg::MOP_KN;
            bfts_pkg::MOP_KN:  mop_next = bfts_pkg::MOP_REL;
            bfts_pkg::MOP_REL: mop_next = bfts_pkg::MOP_TPN;
            bfts_pkg::MOP_TPN: mop_next = bfts_pkg::MOP_FPN;
            default: begin
              dirty_next = 1'b0;
              state_next = S_SUM;
            end
          endcase
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        dop_next   = bfts_pkg::DOP_PREC;
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (step == bfts_pkg::STEP_W'(bfts_pkg::DIV_LAST)) begin
          cmd.div_store = 1'b1;
          state_next    = S_DLOAD;
          case (dop)
            bfts_pkg::DOP_PREC: dop_next = bfts_pkg::DOP_REC;
            bfts_pkg::DOP_REC:  dop_next = bfts_pkg::DOP_F1;
            default:            state_next = S_UPDATE;
          endcase
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = status.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cfg_write) begin
      dirty_next = 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && sample_valid) |=> (state == S_MLOAD || state == S_SUM))
    else $error("accepted sample did not start processing");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result emitted while the output register was occupied");

  a_cfg_marks_dirty: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> dirty)
    else $error("configuration write did not request a scale recompute");

  a_f1_then_update: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSTEP && step == bfts_pkg::STEP_W'(bfts_pkg::DIV_LAST)
     && dop == bfts_pkg::DOP_F1) |=> (state == S_UPDATE))
    else $error("final division did not lead to the best update");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MSTEP) |-> (step <= bfts_pkg::STEP_W'(bfts_pkg::MUL_LAST)))
    else $error("multiplier step counter ran past its last step");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for best_f1_threshold_sweep_top: ranked sample sweeps are
// scored by a cycle-free predictor and every result transaction is compared field by field.
// Depends on bfts_pkg and the block's top level only.

module testbench;

  localparam int SETTLE_CYCLES   = 200;
  localparam int WATCHDOG_CYCLES = 5000;

  logic                           clk;
  logic                           rst          = 1'b1;
  logic                           sample_valid = 1'b0;
  logic                           sample_stall;
  bfts_pkg::sample_t              sample       = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  bfts_pkg::result_t              result;
  logic                           cfg_valid    = 1'b0;
  logic                           cfg_ready;
  logic [bfts_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [bfts_pkg::CFG_W-1:0]     cfg_data     = '0;

  best_f1_threshold_sweep_top u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Predictor copy of the registers and of the sweep state.
  logic [bfts_pkg::EDGE_W-1:0]     total_edges_r       = '0;
  logic [bfts_pkg::NOM_W-1:0]      total_non_edges_r   = '0;
  logic [bfts_pkg::COUNT_BITS-1:0] sampled_edges_r     = 1;
  logic [bfts_pkg::COUNT_BITS-1:0] sampled_non_edges_r = 1;
  logic [bfts_pkg::CNT_W-1:0]      edges_seen_r        = '0;
  logic [bfts_pkg::CNT_W-1:0]      non_edges_seen_r    = '0;
  logic [bfts_pkg::CNT_W-1:0]      position_r          = '0;
  logic [bfts_pkg::Q_W-1:0]        top_f1_r            = '0;
  logic [bfts_pkg::Q_W-1:0]        top_prec_r          = '0;
  logic [bfts_pkg::Q_W-1:0]        top_rec_r           = '0;
  logic [bfts_pkg::CNT_W-1:0]      top_pos_r           = '0;
  logic                            have_top_r          = 1'b0;

  bfts_pkg::result_t sweep_results_q[$];
  bfts_pkg::result_t due;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                n_samples      = 0;
  int                n_results      = 0;
  int                n_writes       = 0;
  int                n_errors       = 0;
  int                n_flagged      = 0;
  int unsigned       quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [bfts_pkg::Q_W-1:0] q_ratio(input logic [127:0] num,
                                                       input logic [127:0] den);
    logic [bfts_pkg::Q_W-1:0] q;
    q = '0;
    if (num >= den) return bfts_pkg::ONE_Q;
    for (int i = 0; i < bfts_pkg::FRAC_BITS; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic void sweep_sample(input bfts_pkg::sample_t s);
    logic [127:0]             tp_num, fp_num, rel_num, ret_num;
    logic [bfts_pkg::Q_W-1:0] prec, rec, f1;
    logic                     bad_counts;
    bfts_pkg::result_t        res;
    prec = '0;
    rec = '0;
    f1 = '0;
    bad_counts = (sampled_edges_r == '0) || (sampled_non_edges_r == '0);
    if (s.is_edge) edges_seen_r = edges_seen_r + 1'b1;
    else non_edges_seen_r = non_edges_seen_r + 1'b1;
    if (!bad_counts) begin
      tp_num = edges_seen_r;
      tp_num = tp_num * total_edges_r * sampled_non_edges_r;
      fp_num = non_edges_seen_r;
      fp_num = fp_num * total_non_edges_r * sampled_edges_r;
      rel_num = total_edges_r;
      rel_num = rel_num * sampled_edges_r * sampled_non_edges_r;
      ret_num = tp_num + fp_num;
      if (ret_num != 0) prec = q_ratio(tp_num, ret_num);
      if (total_edges_r != 0) rec = q_ratio(edges_seen_r, sampled_edges_r);
      if (ret_num + rel_num != 0) f1 = q_ratio(tp_num << 1, ret_num + rel_num);
    end
    if (!have_top_r || f1 > top_f1_r) begin
      have_top_r = 1'b1;
      top_f1_r = f1;
      top_prec_r = prec;
      top_rec_r = rec;
      top_pos_r = position_r;
    end
    position_r = position_r + 1'b1;
    if (s.last) begin
      res = '0;
      if (bad_counts) begin
        res.count_error = 1'b1;
        n_flagged++;
      end else begin
        res.best_precision = top_prec_r;
        res.best_recall = top_rec_r;
        res.best_f1 = top_f1_r;
        res.best_position = top_pos_r;
      end
      sweep_results_q.push_back(res);
      edges_seen_r = '0;
      non_edges_seen_r = '0;
      position_r = '0;
      top_f1_r = '0;
      top_prec_r = '0;
      top_rec_r = '0;
      top_pos_r = '0;
      have_top_r = 1'b0;
    end
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      n_errors++;
    end
  endfunction

  function automatic void set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endfunction

  function automatic logic [bfts_pkg::CFG_W-1:0] rand_word();
    return {16'($urandom_range(65535)), $urandom};
  endfunction

  function automatic logic [bfts_pkg::CFG_W-1:0] graph_size(input int samples);
    case ($urandom_range(3))
      0: return $urandom_range(100);
      1: return samples * $urandom_range(1, 5000);
      2: return $urandom;
      default: return rand_word();
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (sweep_results_q.size() == 0) begin
        $display("%0t: result with nothing pending, got %h", $time, result);
        n_errors++;
      end else begin
        due = sweep_results_q.pop_front();
        check_field("best_precision", due.best_precision, result.best_precision);
        check_field("best_recall", due.best_recall, result.best_recall);
        check_field("best_f1", due.best_f1, result.best_f1);
        check_field("best_position", due.best_position, result.best_position);
        check_field("count_error", due.count_error, result.count_error);
        n_results++;
      end
    end
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("** best_f1_threshold_sweep_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic is_e, input logic is_last);
    bfts_pkg::sample_t s;
    s.is_edge = is_e;
    s.last = is_last;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sweep_sample(s);
    n_samples++;
  endtask

  // Lowers valid in the step of the last accepted transaction, waits for every expected result, then idles.
  task automatic drain();
    sample_valid <= 1'b0;
    while (sweep_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input bfts_pkg::cfg_reg_t idx,
                                input logic [bfts_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bfts_pkg::REG_TOTAL_EDGES:       total_edges_r = data[bfts_pkg::EDGE_W-1:0];
      bfts_pkg::REG_TOTAL_NON_EDGES:   total_non_edges_r = data[bfts_pkg::NOM_W-1:0];
      bfts_pkg::REG_SAMPLED_EDGES:     sampled_edges_r = data[bfts_pkg::COUNT_BITS-1:0];
      bfts_pkg::REG_SAMPLED_NON_EDGES: sampled_non_edges_r = data[bfts_pkg::COUNT_BITS-1:0];
      default: ;
    endcase
    n_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_graph(input logic [bfts_pkg::CFG_W-1:0] m,
                           input logic [bfts_pkg::CFG_W-1:0] nom,
                           input logic [bfts_pkg::CFG_W-1:0] se,
                           input logic [bfts_pkg::CFG_W-1:0] sn);
    drain();
    write_register(bfts_pkg::REG_TOTAL_EDGES, m);
    write_register(bfts_pkg::REG_TOTAL_NON_EDGES, nom);
    write_register(bfts_pkg::REG_SAMPLED_EDGES, se);
    write_register(bfts_pkg::REG_SAMPLED_NON_EDGES, sn);
  endtask

  // With the reset registers precision and F1 are zero over zero, and recall is gated off by the zero total edge count.
  task automatic test_reset_defaults();
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
  endtask

  // All-ones data checks masking to each register's width at the largest graph.
  task automatic test_register_extremes();
    set_graph('1, '1, '1, '1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
  endtask

  task automatic test_small_graph();
    set_graph(10, 35, 3, 3);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
  endtask

  task automatic test_zero_sample_counts();
    set_graph(10, 35, 0, 6);
    send_sample(1'b1, 1'b1);
    set_graph(10, 35, 3, 0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
  endtask

  // More edges than sampled drives recall and F1 past one, where they saturate.
  task automatic test_ratio_saturation();
    set_graph(5, 7, 1, 3);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
  endtask

  task automatic test_zero_over_zero();
    set_graph(0, 9, 2, 2);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
    set_graph(5, 0, 2, 2);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
  endtask

  // Mostly well-formed sweeps whose counts match the sampled registers, in shuffled
  // order with a random lean toward edges first; the rest are random noise sweeps.
  task automatic test_random_sweeps(input int budget);
    int                         sent, sweep, n_edge, n_non, re, rn, bias, len;
    logic                       need_config;
    logic                       is_e;
    logic [bfts_pkg::CFG_W-1:0] se_data, sn_data;
    sent = 0;
    sweep = 0;
    n_edge = 1;
    n_non = 1;
    need_config = 1'b1;
    while (sent < budget) begin
      case ((sweep / 5) % 4)
        0: set_idling(0, 0);
        1: set_idling(70, 0);
        2: set_idling(0, 70);
        default: set_idling(33, 33);
      endcase
      if ($urandom_range(99) < 20) begin
        se_data = ($urandom_range(9) == 0) ? '0 : rand_word();
        sn_data = ($urandom_range(9) == 0) ? '0 : rand_word();
        set_graph(graph_size(30), graph_size(30), se_data, sn_data);
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) send_sample($urandom_range(1), i == len - 1);
        sent += len;
        need_config = 1'b1;
      end else begin
        if (need_config || $urandom_range(2) == 0) begin
          n_edge = ($urandom_range(9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 16);
          n_non = ($urandom_range(9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 16);
          se_data = $urandom_range(1) ? rand_word() : '0;
          sn_data = $urandom_range(1) ? rand_word() : '0;
          se_data[bfts_pkg::COUNT_BITS-1:0] = n_edge;
          sn_data[bfts_pkg::COUNT_BITS-1:0] = n_non;
          set_graph(graph_size(n_edge), graph_size(n_non), se_data, sn_data);
          need_config = 1'b0;
        end
        re = n_edge;
        rn = n_non;
        bias = $urandom_range(1, 4);
        while (re + rn > 0) begin
          is_e = ($urandom_range(1, re * bias + rn) <= re * bias);
          send_sample(is_e, re + rn == 1);
          if (is_e) re--;
          else rn--;
        end
        sent += n_edge + n_non;
      end
      sweep++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_small_graph();
    test_zero_sample_counts();
    test_ratio_saturation();
    test_zero_over_zero();
    test_random_sweeps(1830);
    set_idling(0, 0);
    drain();
    $display("Run covered %0d samples, %0d register writes and %0d checked results,",
             n_samples, n_writes, n_results);
    $display("%0d of them flagging a zero sampled count; %0d mismatches.",
             n_flagged, n_errors);
    if (n_errors == 0) begin
      $display("** best_f1_threshold_sweep_top: PASSED **");
    end else begin
      $display("** best_f1_threshold_sweep_top: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
hdl/bfts_pkg.sv
hdl/bfts_dp.sv
hdl/bfts_ctrl.sv
hdl/best_f1_threshold_sweep_top.sv
tb/testbench.sv
